### rtl/sqs_pkg.sv
// Shared constants, types and helpers for the sprite quad setup pipeline.
package sqs_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int COORD_FRAC_BITS = 8;

  localparam int POS_W   = 24;
  localparam int TEXEL_W = 16;
  localparam int UV_FRAC = 16;
  localparam int UV_W    = 20;
  localparam int ANG_W   = 17;
  localparam int TAG_W   = 64;

  // extent of a rectangle side, wide enough for the default full-texture size
  localparam int EXT_W  = ((TEXEL_W + COORD_FRAC_BITS >= POS_W) ?
                           TEXEL_W + COORD_FRAC_BITS : POS_W) + 1;
  localparam int CEN_W  = EXT_W + 1;
  localparam int OFF_W  = EXT_W + 2;
  localparam int CS_W   = 32;
  localparam int PROD_W = OFF_W + CS_W;
  localparam int ACC_W  = PROD_W + 3;

  localparam int NUM_W = TEXEL_W + 1 + UV_FRAC + 1;
  localparam int REM_W = TEXEL_W + 1;
  localparam int NITER = (CORDIC_STEPS > UV_W) ? CORDIC_STEPS : UV_W;

  localparam int AM_W = 16;
  localparam int AF_W = 15;
  localparam int ZP_W = AF_W + 27;

  localparam int ANG_FULL   = 46080;
  localparam int ANG_HALF   = 23040;
  localparam int ANG_QTR    = 11520;
  localparam int RAD_SCALE  = 37480660;
  localparam int Q30_SHIFT  = 30;
  localparam int POS_SHIFT  = 31;

  localparam logic signed [CS_W-1:0] CORDIC_X0 = 32'sh26DD3B6A;
  localparam logic signed [CS_W-1:0] ONE_Q30   = 32'sh40000000;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  function automatic logic signed [CS_W-1:0] atan_q30(input int i);
    logic signed [CS_W-1:0] r;
    unique case (i)
      0:       r = 32'sh3243F6A8;
      1:       r = 32'sh1DAC6705;
      2:       r = 32'sh0FADBAFC;
      3:       r = 32'sh07F56EA6;
      4:       r = 32'sh03FEAB76;
      5:       r = 32'sh01FFD55B;
      6:       r = 32'sh00FFFAAA;
      7:       r = 32'sh007FFF55;
      8:       r = 32'sh003FFFEA;
      9:       r = 32'sh001FFFFD;
      default: r = 32'sd1 <<< (Q30_SHIFT - i);
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic                            fh;
    logic                            fv;
    logic [TAG_W-1:0]                tag;
    logic signed [CEN_W-1:0]         cx2;
    logic signed [CEN_W-1:0]         cy2;
    logic signed [CEN_W-1:0]         dw2;
    logic signed [CEN_W-1:0]         dh2;
    logic signed [OFF_W-1:0]         ex0;
    logic signed [OFF_W-1:0]         ey0;
    logic                            rot;
    logic                            neg;
    logic signed [CS_W-1:0]          cx;
    logic signed [CS_W-1:0]          cy;
    logic signed [CS_W-1:0]          cz;
    logic [TEXEL_W-1:0]              tw;
    logic [TEXEL_W-1:0]              th;
    logic [3:0][UV_W-1:0]            nlo;
    logic [3:0][REM_W-1:0]           rem;
    logic [3:0][UV_W-1:0]            quo;
    logic [3:0]                      sat;
  } sqs_item_t;

  typedef struct packed {
    logic                       fh;
    logic                       fv;
    logic [TAG_W-1:0]           tag;
    logic [3:0][POS_W-1:0]      px;
    logic [3:0][POS_W-1:0]      py;
    logic [1:0][UV_W-1:0]       u;
    logic [1:0][UV_W-1:0]       v;
  } sqs_quad_t;

endpackage

### rtl/sqs_front.sv
// Request decode, angle wrap and fold, divider set-up and angle to radians.
module sqs_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic                                in_mode,
  input  logic signed [sqs_pkg::POS_W-1:0]    in_dst_x,
  input  logic signed [sqs_pkg::POS_W-1:0]    in_dst_y,
  input  logic signed [sqs_pkg::POS_W-1:0]    in_dst_w,
  input  logic signed [sqs_pkg::POS_W-1:0]    in_dst_h,
  input  logic [63:0]                         in_src_rect,
  input  logic [31:0]                         in_tex_size,
  input  logic [47:0]                         in_center_offset,
  input  logic signed [sqs_pkg::ANG_W-1:0]    in_angle_step,
  input  logic [1:0]                          in_flip_bits,
  input  logic [2:0]                          in_given_flags,
  input  logic [sqs_pkg::TAG_W-1:0]           in_command_tag,
  output logic                                out_v,
  output sqs_pkg::sqs_item_t                  out_item
);
  import sqs_pkg::*;

  localparam logic signed [ANG_W:0] FULL_S = (ANG_W+1)'(ANG_FULL);
  localparam logic signed [ANG_W:0] HALF_S = (ANG_W+1)'(ANG_HALF);
  localparam logic signed [ANG_W:0] QTR_S  = (ANG_W+1)'(ANG_QTR);
  localparam logic signed [26:0]    RAD_S  = 27'(RAD_SCALE);

  // ---- stage 0: decode ----
  logic [TEXEL_W-1:0]            tw, th, sx, sy, sw, sh;
  logic                          dg, sg;
  logic signed [POS_W-1:0]       dx_d, dy_d;
  logic signed [EXT_W-1:0]       dw_d, dh_d;
  logic                          keep;
  logic [3:0][TEXEL_W:0]         tex_d;
  logic [TEXEL_W-1:0]            szu_d, szv_d;
  logic signed [ANG_W:0]         a1, a2;

  always_comb begin
    tw = in_tex_size[TEXEL_W-1:0];
    th = in_tex_size[2*TEXEL_W-1:TEXEL_W];
    sx = in_src_rect[15:0];
    sy = in_src_rect[31:16];
    sw = in_src_rect[47:32];
    sh = in_src_rect[63:48];
    dg = in_given_flags[0];
    sg = in_given_flags[1];
    dx_d = dg ? in_dst_x : '0;
    dy_d = dg ? in_dst_y : '0;
    dw_d = dg ? EXT_W'(in_dst_w) :
           $signed({{(EXT_W-TEXEL_W-COORD_FRAC_BITS){1'b0}}, tw,
                    {COORD_FRAC_BITS{1'b0}}});
    dh_d = dg ? EXT_W'(in_dst_h) :
           $signed({{(EXT_W-TEXEL_W-COORD_FRAC_BITS){1'b0}}, th,
                    {COORD_FRAC_BITS{1'b0}}});
    keep = (tw != '0) && (th != '0) && !(in_mode && !dg) && (dw_d > 0) && (dh_d > 0);
    // no source: size one with texels 0 and 1 gives 0 and 1.0
    if (sg) begin
      tex_d[0] = {1'b0, sx};
      tex_d[1] = {1'b0, sx} + {1'b0, sw};
      tex_d[2] = {1'b0, sy};
      tex_d[3] = {1'b0, sy} + {1'b0, sh};
      szu_d    = tw;
      szv_d    = th;
    end else begin
      tex_d[0] = '0;
      tex_d[1] = (TEXEL_W+1)'(1);
      tex_d[2] = '0;
      tex_d[3] = (TEXEL_W+1)'(1);
      szu_d    = TEXEL_W'(1);
      szv_d    = TEXEL_W'(1);
    end
    // wrap into [0, full turn)
    a1 = (ANG_W+1)'(in_angle_step);
    if (a1 < 0) a1 = a1 + FULL_S;
    if (a1 < 0) a2 = a1 + FULL_S;
    else if (a1 >= FULL_S) a2 = a1 - FULL_S;
    else a2 = a1;
  end

  logic                          s0_v_r;
  logic                          s0_mode_r, s0_cg_r, s0_fh_r, s0_fv_r;
  logic signed [POS_W-1:0]       s0_dx_r, s0_dy_r, s0_cox_r, s0_coy_r;
  logic signed [EXT_W-1:0]       s0_dw_r, s0_dh_r;
  logic [TAG_W-1:0]              s0_tag_r;
  logic [AM_W-1:0]               s0_am_r;
  logic [3:0][TEXEL_W:0]         s0_tex_r;
  logic [TEXEL_W-1:0]            s0_szu_r, s0_szv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_mode_r <= in_mode;
      s0_cg_r   <= in_given_flags[2];
      s0_fh_r   <= in_mode & in_flip_bits[0];
      s0_fv_r   <= in_mode & in_flip_bits[1];
      s0_dx_r   <= dx_d;
      s0_dy_r   <= dy_d;
      s0_cox_r  <= $signed(in_center_offset[23:0]);
      s0_coy_r  <= $signed(in_center_offset[47:24]);
      s0_dw_r   <= dw_d;
      s0_dh_r   <= dh_d;
      s0_tag_r  <= in_command_tag;
      s0_am_r   <= AM_W'(a2);
      s0_tex_r  <= tex_d;
      s0_szu_r  <= szu_d;
      s0_szv_r  <= szv_d;
    end
  end

  // ---- stage 1: centre, offsets, numerators, fold ----
  logic [3:0][NUM_W-1:0]         num;
  logic [TEXEL_W-1:0]            sz;
  logic signed [ANG_W:0]         a_s, a_f;
  logic                          neg_c;
  sqs_item_t                     s1_nxt;

  always_comb begin
    s1_nxt     = '0;
    s1_nxt.fh  = s0_fh_r;
    s1_nxt.fv  = s0_fv_r;
    s1_nxt.tag = s0_tag_r;
    s1_nxt.cx2 = s0_cg_r ? ((CEN_W'(s0_dx_r) + CEN_W'(s0_cox_r)) <<< 1) :
                           ((CEN_W'(s0_dx_r) <<< 1) + CEN_W'(s0_dw_r));
    s1_nxt.cy2 = s0_cg_r ? ((CEN_W'(s0_dy_r) + CEN_W'(s0_coy_r)) <<< 1) :
                           ((CEN_W'(s0_dy_r) <<< 1) + CEN_W'(s0_dh_r));
    s1_nxt.dw2 = CEN_W'(s0_dw_r) <<< 1;
    s1_nxt.dh2 = CEN_W'(s0_dh_r) <<< 1;
    // top-left offset from centre, doubled
    s1_nxt.ex0 = s0_cg_r ? -(OFF_W'(s0_cox_r) <<< 1) : -OFF_W'(s0_dw_r);
    s1_nxt.ey0 = s0_cg_r ? -(OFF_W'(s0_coy_r) <<< 1) : -OFF_W'(s0_dh_r);
    s1_nxt.tw  = s0_szu_r;
    s1_nxt.th  = s0_szv_r;
    s1_nxt.cx  = CORDIC_X0;
    sz = '0;
    for (int d = 0; d < 4; d++) begin
      sz = (d < 2) ? s0_szu_r : s0_szv_r;
      num[d] = NUM_W'({s0_tex_r[d], {UV_FRAC{1'b0}}}) + NUM_W'(sz[TEXEL_W-1:1]);
      s1_nxt.nlo[d] = num[d][UV_W-1:0];
      s1_nxt.rem[d] = REM_W'(num[d][NUM_W-1:UV_W]);
      s1_nxt.sat[d] = REM_W'(num[d][NUM_W-1:UV_W]) >= REM_W'(sz);
    end
    a_s = ($signed({2'b00, s0_am_r}) > HALF_S) ? $signed({2'b00, s0_am_r}) - FULL_S :
                                                $signed({2'b00, s0_am_r});
    s1_nxt.rot = s0_mode_r && (a_s != 0);
    if (a_s > QTR_S) begin
      a_f   = a_s - HALF_S;
      neg_c = 1'b1;
    end else if (a_s < -QTR_S) begin
      a_f   = a_s + HALF_S;
      neg_c = 1'b1;
    end else begin
      a_f   = a_s;
      neg_c = 1'b0;
    end
    s1_nxt.neg = neg_c;
  end

  logic                      s1_v_r;
  sqs_item_t                 s1_item_r;
  logic signed [AF_W-1:0]    s1_af_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= s1_nxt;
      s1_af_r   <= AF_W'(a_f);
    end
  end

  // ---- stage 2: angle to Q2.30 radians ----
  logic signed [ZP_W-1:0]    zp;
  sqs_item_t                 s2_nxt;

  always_comb begin
    zp        = ZP_W'(s1_af_r) * ZP_W'(RAD_S) + ZP_W'(128);
    s2_nxt    = s1_item_r;
    s2_nxt.cz = CS_W'(zp >>> 8);
  end

  logic                      s2_v_r;
  sqs_item_t                 s2_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item_r <= s2_nxt;
    end
  end

  assign out_v    = s2_v_r;
  assign out_item = s2_item_r;

endmodule

### rtl/sqs_iter.sv
// Iteration pipeline: one CORDIC step (first CORDIC_STEPS stages) and one quotient bit of each divider per stage.
module sqs_iter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_v,
  input  sqs_pkg::sqs_item_t  in_item,
  output logic                out_v,
  output sqs_pkg::sqs_item_t  out_item
);
  import sqs_pkg::*;

  sqs_item_t st_r [NITER];
  logic      v_r  [NITER];

  for (genvar j = 0; j < NITER; j++) begin : g_stg
    sqs_item_t                   src, stg_nxt;
    logic                        src_v;
    logic signed [CS_W-1:0]      x_n, y_n, z_n;
    logic [3:0][REM_W-1:0]       rem_n;
    logic [3:0][UV_W-1:0]        quo_n;

    if (j == 0) begin : g_first
      assign src   = in_item;
      assign src_v = in_v;
    end else begin : g_next
      assign src   = st_r[j-1];
      assign src_v = v_r[j-1];
    end

    if (j < CORDIC_STEPS) begin : g_rot
      always_comb begin
        logic signed [CS_W-1:0] xs, ys;
        xs = $signed(src.cx) >>> j;
        ys = $signed(src.cy) >>> j;
        if ($signed(src.cz) >= 0) begin
          x_n = src.cx - ys;
          y_n = src.cy + xs;
          z_n = src.cz - atan_q30(j);
        end else begin
          x_n = src.cx + ys;
          y_n = src.cy - xs;
          z_n = src.cz + atan_q30(j);
        end
      end
    end else begin : g_rot_pass
      assign x_n = src.cx;
      assign y_n = src.cy;
      assign z_n = src.cz;
    end

    if (j < UV_W) begin : g_div
      always_comb begin
        logic [REM_W-1:0]   rr;
        logic [TEXEL_W-1:0] sz;
        rr = '0;
        sz = '0;
        for (int d = 0; d < 4; d++) begin
          sz = (d < 2) ? src.tw : src.th;
          rr = {src.rem[d][TEXEL_W-1:0], src.nlo[d][UV_W-1-j]};
          if (rr >= REM_W'(sz)) begin
            rem_n[d] = rr - REM_W'(sz);
            quo_n[d] = {src.quo[d][UV_W-2:0], 1'b1};
          end else begin
            rem_n[d] = rr;
            quo_n[d] = {src.quo[d][UV_W-2:0], 1'b0};
          end
        end
      end
    end else begin : g_div_pass
      assign rem_n = src.rem;
      assign quo_n = src.quo;
    end

    always_comb begin
      stg_nxt     = src;
      stg_nxt.cx  = x_n;
      stg_nxt.cy  = y_n;
      stg_nxt.cz  = z_n;
      stg_nxt.rem = rem_n;
      stg_nxt.quo = quo_n;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv) begin
        v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[j] <= stg_nxt;
      end
    end
  end

  assign out_v    = v_r[NITER-1];
  assign out_item = st_r[NITER-1];

endmodule

### rtl/sqs_corner.sv
// Corner positions: sine/cosine select, products, sums, rounding and saturation.
module sqs_corner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_v,
  input  sqs_pkg::sqs_item_t  in_item,
  output logic                out_v,
  output sqs_pkg::sqs_quad_t  out_quad
);
  import sqs_pkg::*;

  localparam int SH_W = ACC_W - POS_SHIFT;
  localparam logic signed [SH_W-1:0] SH_MAX = SH_W'(2**(POS_W-1) - 1);
  localparam logic signed [SH_W-1:0] SH_MIN = SH_W'(-(2**(POS_W-1)));
  localparam logic signed [ACC_W-1:0] HALF_RND = ACC_W'(1) <<< Q30_SHIFT;

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] acc);
    logic signed [SH_W-1:0] sh;
    logic [POS_W-1:0]       r;
    sh = SH_W'(acc >>> POS_SHIFT);
    priority if (sh > SH_MAX) r = {1'b0, {(POS_W-1){1'b1}}};
    else if (sh < SH_MIN)     r = {1'b1, {(POS_W-1){1'b0}}};
    else                      r = sh[POS_W-1:0];
    return r;
  endfunction

  // ---- c1: cosine/sine, saturated texture coordinates ----
  logic                      c1_v_r;
  sqs_item_t                 c1_item_r;
  logic signed [CS_W-1:0]    c1_c_r, c1_s_r;
  logic [3:0][UV_W-1:0]      c1_uv_r;
  logic signed [CS_W-1:0]    c_nxt, s_nxt;
  logic [3:0][UV_W-1:0]      uv_nxt;

  always_comb begin
    // without rotation a unit cosine gives the exact corner sums
    if (in_item.rot) begin
      c_nxt = in_item.neg ? -in_item.cx : in_item.cx;
      s_nxt = in_item.neg ? -in_item.cy : in_item.cy;
    end else begin
      c_nxt = ONE_Q30;
      s_nxt = '0;
    end
    for (int d = 0; d < 4; d++) begin
      uv_nxt[d] = in_item.sat[d] ? {UV_W{1'b1}} : in_item.quo[d];
    end
  end

  // ---- c2: products ----
  logic                      c2_v_r;
  logic signed [PROD_W-1:0]  p_ex0c_r, p_ey0s_r, p_ex0s_r, p_ey0c_r;
  logic signed [PROD_W-1:0]  p_dw2c_r, p_dh2s_r, p_dw2s_r, p_dh2c_r;
  logic signed [CEN_W-1:0]   c2_cx2_r, c2_cy2_r;
  logic [3:0][UV_W-1:0]      c2_uv_r;
  logic                      c2_fh_r, c2_fv_r;
  logic [TAG_W-1:0]          c2_tag_r;

  // ---- c3: top-left sums and per-side deltas ----
  logic                      c3_v_r;
  logic signed [ACC_W-1:0]   c3_x0_r, c3_y0_r, c3_dxw_r, c3_dxh_r, c3_dyw_r, c3_dyh_r;
  logic [3:0][UV_W-1:0]      c3_uv_r;
  logic                      c3_fh_r, c3_fv_r;
  logic [TAG_W-1:0]          c3_tag_r;
  logic signed [ACC_W-1:0]   x0_nxt, y0_nxt;

  always_comb begin
    x0_nxt = (ACC_W'(c2_cx2_r) <<< Q30_SHIFT) + HALF_RND + ACC_W'(p_ex0c_r) -
             ACC_W'(p_ey0s_r);
    y0_nxt = (ACC_W'(c2_cy2_r) <<< Q30_SHIFT) + HALF_RND + ACC_W'(p_ex0s_r) +
             ACC_W'(p_ey0c_r);
  end

  // ---- c4: single-side corners ----
  logic                      c4_v_r;
  logic signed [ACC_W-1:0]   c4_x0_r, c4_x1_r, c4_x2_r, c4_dxh_r;
  logic signed [ACC_W-1:0]   c4_y0_r, c4_y1_r, c4_y2_r, c4_dyh_r;
  logic [3:0][UV_W-1:0]      c4_uv_r;
  logic                      c4_fh_r, c4_fv_r;
  logic [TAG_W-1:0]          c4_tag_r;

  // ---- c5: far corner, round and saturate ----
  logic                      c5_v_r;
  sqs_quad_t                 c5_quad_r;
  sqs_quad_t                 quad_nxt;

  always_comb begin
    quad_nxt.fh    = c4_fh_r;
    quad_nxt.fv    = c4_fv_r;
    quad_nxt.tag   = c4_tag_r;
    quad_nxt.px[0] = sat_pos(c4_x0_r);
    quad_nxt.px[1] = sat_pos(c4_x1_r);
    quad_nxt.px[2] = sat_pos(c4_x2_r);
    quad_nxt.px[3] = sat_pos(c4_x1_r + c4_dxh_r);
    quad_nxt.py[0] = sat_pos(c4_y0_r);
    quad_nxt.py[1] = sat_pos(c4_y1_r);
    quad_nxt.py[2] = sat_pos(c4_y2_r);
    quad_nxt.py[3] = sat_pos(c4_y1_r + c4_dyh_r);
    quad_nxt.u[0]  = c4_uv_r[0];
    quad_nxt.u[1]  = c4_uv_r[1];
    quad_nxt.v[0]  = c4_uv_r[2];
    quad_nxt.v[1]  = c4_uv_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      c3_v_r <= 1'b0;
      c4_v_r <= 1'b0;
      c5_v_r <= 1'b0;
    end else if (adv) begin
      c1_v_r <= in_v;
      c2_v_r <= c1_v_r;
      c3_v_r <= c2_v_r;
      c4_v_r <= c3_v_r;
      c5_v_r <= c4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_item_r <= in_item;
      c1_c_r    <= c_nxt;
      c1_s_r    <= s_nxt;
      c1_uv_r   <= uv_nxt;

      p_ex0c_r  <= c1_item_r.ex0 * c1_c_r;
      p_ey0s_r  <= c1_item_r.ey0 * c1_s_r;
      p_ex0s_r  <= c1_item_r.ex0 * c1_s_r;
      p_ey0c_r  <= c1_item_r.ey0 * c1_c_r;
      p_dw2c_r  <= c1_item_r.dw2 * c1_c_r;
      p_dh2s_r  <= c1_item_r.dh2 * c1_s_r;
      p_dw2s_r  <= c1_item_r.dw2 * c1_s_r;
      p_dh2c_r  <= c1_item_r.dh2 * c1_c_r;
      c2_cx2_r  <= c1_item_r.cx2;
      c2_cy2_r  <= c1_item_r.cy2;
      c2_uv_r   <= c1_uv_r;
      c2_fh_r   <= c1_item_r.fh;
      c2_fv_r   <= c1_item_r.fv;
      c2_tag_r  <= c1_item_r.tag;

      c3_x0_r   <= x0_nxt;
      c3_y0_r   <= y0_nxt;
      c3_dxw_r  <= ACC_W'(p_dw2c_r);
      c3_dxh_r  <= -ACC_W'(p_dh2s_r);
      c3_dyw_r  <= ACC_W'(p_dw2s_r);
      c3_dyh_r  <= ACC_W'(p_dh2c_r);
      c3_uv_r   <= c2_uv_r;
      c3_fh_r   <= c2_fh_r;
      c3_fv_r   <= c2_fv_r;
      c3_tag_r  <= c2_tag_r;

      c4_x0_r   <= c3_x0_r;
      c4_x1_r   <= c3_x0_r + c3_dxw_r;
      c4_x2_r   <= c3_x0_r + c3_dxh_r;
      c4_dxh_r  <= c3_dxh_r;
      c4_y0_r   <= c3_y0_r;
      c4_y1_r   <= c3_y0_r + c3_dyw_r;
      c4_y2_r   <= c3_y0_r + c3_dyh_r;
      c4_dyh_r  <= c3_dyh_r;
      c4_uv_r   <= c3_uv_r;
      c4_fh_r   <= c3_fh_r;
      c4_fv_r   <= c3_fv_r;
      c4_tag_r  <= c3_tag_r;

      c5_quad_r <= quad_nxt;
    end
  end

  assign out_v    = c5_v_r;
  assign out_quad = c5_quad_r;

endmodule

### rtl/sprite_quad_setup.sv
// Sprite quad setup top level: front end, iteration pipeline, corner maths, corner serialiser.
//
//  channel  ports          direction  moves
//  input    in_valid/ready in         one sprite draw request
//  output   out_valid/ready out       one corner vertex, four per request
//
// The pipeline is 3 + max(CORDIC_STEPS, 20) + 5 stages deep (28 at default settings),
// then a holding register that hands out the four corners one per cycle while out_ready is high.
// Sustained rate is set by that serialiser, which takes the next quad as it hands out its last corner.
// Rejected requests are taken in and dropped at decode; they give no corners.
// rst_n clears the valid bits of every stage and the serialiser; no clearing pass.
// A stall on out_ready freezes the whole pipeline once its last stage holds a quad; nothing is lost or repeated.
module sprite_quad_setup (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic signed [sqs_pkg::POS_W-1:0]    in_dst_x,
  input  logic signed [sqs_pkg::POS_W-1:0]    in_dst_y,
  input  logic signed [sqs_pkg::POS_W-1:0]    in_dst_w,
  input  logic signed [sqs_pkg::POS_W-1:0]    in_dst_h,
  input  logic [63:0]                         in_src_rect,
  input  logic [31:0]                         in_tex_size,
  input  logic [47:0]                         in_center_offset,
  input  logic signed [sqs_pkg::ANG_W-1:0]    in_angle_step,
  input  logic [1:0]                          in_flip_bits,
  input  logic [2:0]                          in_given_flags,
  input  logic [sqs_pkg::TAG_W-1:0]           in_command_tag,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_corner,
  output logic signed [sqs_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [sqs_pkg::POS_W-1:0]    out_pos_y,
  output logic [sqs_pkg::UV_W-1:0]            out_tex_u,
  output logic [sqs_pkg::UV_W-1:0]            out_tex_v,
  output logic [sqs_pkg::TAG_W-1:0]           out_tag_out,
  output logic                                out_last
);
  import sqs_pkg::*;

  logic        adv;
  logic        fr_v, it_v, tail_v;
  sqs_item_t   fr_item, it_item;
  sqs_quad_t   tail_quad;

  logic        ser_v_r;
  logic [1:0]  cnt_r;
  sqs_quad_t   quad_r;
  logic        load_ok;

  // serialiser takes a new quad when empty or handing out its last corner
  assign load_ok  = !ser_v_r || (out_ready && (cnt_r == CORNER_LAST));
  assign adv      = !tail_v || load_ok;
  assign in_ready = adv;

  sqs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .in_valid         (in_valid),
    .in_mode          (in_mode),
    .in_dst_x         (in_dst_x),
    .in_dst_y         (in_dst_y),
    .in_dst_w         (in_dst_w),
    .in_dst_h         (in_dst_h),
    .in_src_rect      (in_src_rect),
    .in_tex_size      (in_tex_size),
    .in_center_offset (in_center_offset),
    .in_angle_step    (in_angle_step),
    .in_flip_bits     (in_flip_bits),
    .in_given_flags   (in_given_flags),
    .in_command_tag   (in_command_tag),
    .out_v            (fr_v),
    .out_item         (fr_item)
  );

  sqs_iter u_iter (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (fr_v),
    .in_item  (fr_item),
    .out_v    (it_v),
    .out_item (it_item)
  );

  sqs_corner u_corner (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (it_v),
    .in_item  (it_item),
    .out_v    (tail_v),
    .out_quad (tail_quad)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (ser_v_r && out_ready) cnt_r <= cnt_r + 2'd1;
      if (load_ok) ser_v_r <= tail_v;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && tail_v) quad_r <= tail_quad;
  end

  assign out_valid   = ser_v_r;
  assign out_corner  = cnt_r;
  assign out_pos_x   = quad_r.px[cnt_r];
  assign out_pos_y   = quad_r.py[cnt_r];
  assign out_tex_u   = quad_r.u[cnt_r[0] ^ quad_r.fh];
  assign out_tex_v   = quad_r.v[cnt_r[1] ^ quad_r.fv];
  assign out_tag_out = quad_r.tag;
  assign out_last    = (cnt_r == CORNER_LAST);

endmodule
